### design/gws_pkg.sv
// ----------------------------------------------------------------------------
// gws_pkg
// Shared types, sizes and direction tables for the eight-direction word
// search block.
// ----------------------------------------------------------------------------
`default_nettype none

package gws_pkg;

    // Grid and word store shape
    localparam int GRID_ROWS = 8;
    localparam int GRID_COLS = 8;
    localparam int MAX_WORD  = 16;

    // Derived index widths
    localparam int ROW_W   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int COL_W   = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int ADDR_W  = ROW_W + COL_W;
    localparam int CELLS   = 1 << ADDR_W;
    localparam int WIDX_W  = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

    // Walk positions carry one extra bit so a step off either edge shows
    localparam int POS_RW  = ROW_W + 1;
    localparam int POS_CW  = COL_W + 1;

    // Fixed field widths
    localparam int LEN_W   = 5;
    localparam int COUNT_W = 10;
    localparam int DIR_W   = 3;

    localparam logic [7:0]         BLANK_MARK = 8'h30;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [DIR_W-1:0]   LAST_DIR   = {DIR_W{1'b1}};

    typedef enum logic [1:0] {
        OP_LOAD_GRID = 2'd0,
        OP_LOAD_WORD = 2'd1,
        OP_SEARCH    = 2'd2,
        OP_READ_MARK = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] grid_row;
        logic [2:0] grid_col;
        logic [7:0] letter;
        logic [3:0] word_index;
        logic [4:0] word_length;
    } req_t;

    typedef struct packed {
        logic [7:0]  cell_value;
        logic [9:0]  match_count;
        logic        bad_request;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic line_init;
        logic advance;
        logic rd_letter;
        logic wr_mark;
        logic count_inc;
        logic next_line;
        logic finish;
    } gws_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic oob;
        logic letter_eq;
        logic last_step;
        logic last_line;
        logic req_bad;
    } gws_status_t;

    // Row step per direction, N first and clockwise, two's complement
    function automatic logic [1:0] dir_row_step(input logic [DIR_W-1:0] d);
        logic [1:0] s;
        case (d)
            3'd0, 3'd1, 3'd7: s = 2'b11;
            3'd3, 3'd4, 3'd5: s = 2'b01;
            default:          s = 2'b00;
        endcase
        return s;
    endfunction

    // Column step per direction
    function automatic logic [1:0] dir_col_step(input logic [DIR_W-1:0] d);
        logic [1:0] s;
        case (d)
            3'd1, 3'd2, 3'd3: s = 2'b01;
            3'd5, 3'd6, 3'd7: s = 2'b11;
            default:          s = 2'b00;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### design/gws_ctrl.sv
// ----------------------------------------------------------------------------
// gws_ctrl
// Sequencer for the word search: takes words, walks the line checks and
// mark passes, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module gws_ctrl
    import gws_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire op_t         req_op,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output gws_cmd_t         cmd,
    input  wire gws_status_t status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LINE,
        S_STEP,
        S_CMP,
        S_MARK,
        S_NEXT,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_busy;
    logic   accept;

    // Hold new words while searching or while the result waits
    assign out_busy  = out_valid_reg && rsp_stall;
    assign req_stall = (state_reg != S_IDLE) || out_busy;
    assign accept    = (state_reg == S_IDLE) && req_valid && !out_busy;
    assign rsp_valid = out_valid_reg;

    // Decode commands and next state
    always_comb
    begin
        cmd            = '0;
        cmd.accept     = accept;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_op == OP_SEARCH && !status.req_bad)
                        state_next = S_LINE;
                    else
                        out_valid_next = 1'b1;
                end
            end
            S_LINE:
            begin
                cmd.line_init = 1'b1;
                state_next    = S_STEP;
            end
            S_STEP:
            begin
                if (status.oob)
                    state_next = S_NEXT;
                else
                begin
                    cmd.rd_letter = 1'b1;
                    state_next    = S_CMP;
                end
            end
            S_CMP:
            begin
                if (!status.letter_eq)
                    state_next = S_NEXT;
                else if (status.last_step)
                begin
                    cmd.count_inc = 1'b1;
                    cmd.line_init = 1'b1;
                    state_next    = S_MARK;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_STEP;
                end
            end
            S_MARK:
            begin
                cmd.wr_mark = 1'b1;
                if (status.last_step)
                    state_next = S_NEXT;
                else
                    cmd.advance = 1'b1;
            end
            S_NEXT:
            begin
                if (status.last_line)
                    state_next = S_FINISH;
                else
                begin
                    cmd.next_line = 1'b1;
                    state_next    = S_LINE;
                end
            end
            S_FINISH:
            begin
                cmd.finish     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### design/gws_datapath.sv
// ----------------------------------------------------------------------------
// gws_datapath
// Letter grid, word store, mark grid and the walk registers that the
// controller steps through origins, directions and letters.
// ----------------------------------------------------------------------------
`default_nettype none

module gws_datapath
    import gws_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire req_t     req,
    input  wire gws_cmd_t cmd,
    output gws_status_t   status,
    output rsp_t          rsp
);

    logic [7:0]         letter_mem [CELLS];
    logic [7:0]         mark_mem   [CELLS];
    logic [7:0]         word_reg   [MAX_WORD];
    logic [CELLS-1:0]   mark_vld_reg;

    logic [ROW_W-1:0]   orow_reg;
    logic [COL_W-1:0]   ocol_reg;
    logic [DIR_W-1:0]   dir_reg;
    logic [POS_RW-1:0]  cur_r_reg;
    logic [POS_CW-1:0]  cur_c_reg;
    logic [LEN_W-1:0]   step_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [7:0]         letter_rd_reg;

    logic [7:0]         mark_rd_reg;
    logic               mark_rd_vld_reg;
    logic               cell_sel_reg;
    logic [COUNT_W-1:0] res_count_reg;
    logic               res_bad_reg;

    logic               in_grid;
    logic               widx_ok;
    logic [ADDR_W-1:0]  req_addr;
    logic [ADDR_W-1:0]  cur_addr;
    logic [7:0]         word_at_step;
    logic [1:0]         dr;
    logic [1:0]         dc;
    logic               is_op_grid;
    logic               is_op_word;
    logic               is_op_search;
    logic               is_op_read;

    // Decode the incoming word
    assign is_op_grid   = (req.op == OP_LOAD_GRID);
    assign is_op_word   = (req.op == OP_LOAD_WORD);
    assign is_op_search = (req.op == OP_SEARCH);
    assign is_op_read   = (req.op == OP_READ_MARK);
    assign in_grid      = (int'(req.grid_row) < GRID_ROWS) && (int'(req.grid_col) < GRID_COLS);
    assign widx_ok      = (int'(req.word_index) < MAX_WORD);
    assign req_addr     = {ROW_W'(req.grid_row), COL_W'(req.grid_col)};

    // Walk position and direction steps
    assign cur_addr     = {cur_r_reg[ROW_W-1:0], cur_c_reg[COL_W-1:0]};
    assign word_at_step = word_reg[WIDX_W'(step_reg)];
    assign dr           = dir_row_step(dir_reg);
    assign dc           = dir_col_step(dir_reg);

    // Report status to the controller
    assign status.oob       = (cur_r_reg >= POS_RW'(GRID_ROWS)) ||
                              (cur_c_reg >= POS_CW'(GRID_COLS));
    assign status.letter_eq = (letter_rd_reg == word_at_step);
    assign status.last_step = (step_reg == (len_reg - LEN_W'(1)));
    assign status.last_line = (dir_reg == LAST_DIR) &&
                              (orow_reg == ROW_W'(GRID_ROWS - 1)) &&
                              (ocol_reg == COL_W'(GRID_COLS - 1));
    assign status.req_bad   = (req.word_length == '0) ||
                              (int'(req.word_length) > MAX_WORD);

    // Letter grid: load writes, walk reads
    always_ff @(posedge clk)
    begin
        if (cmd.accept && is_op_grid && in_grid)
            letter_mem[req_addr] <= req.letter;
        if (cmd.rd_letter)
            letter_rd_reg <= letter_mem[cur_addr];
    end

    // Word store
    always_ff @(posedge clk)
    begin
        if (cmd.accept && is_op_word && widx_ok)
            word_reg[WIDX_W'(req.word_index)] <= req.letter;
    end

    // Mark grid: mark pass writes, read words read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_mark)
            mark_mem[cur_addr] <= word_at_step;
        if (cmd.accept && is_op_read)
        begin
            mark_rd_reg     <= mark_mem[req_addr];
            mark_rd_vld_reg <= mark_vld_reg[req_addr];
        end
    end

    // Mark valid bits: clear at reset and at the start of a search with a legal length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mark_vld_reg <= '0;
        else if (cmd.accept && is_op_search && !status.req_bad)
            mark_vld_reg <= '0;
        else if (cmd.wr_mark)
            mark_vld_reg[cur_addr] <= 1'b1;
    end

    // Walk registers: origin, direction, position, step and count
    always_ff @(posedge clk)
    begin
        if (cmd.accept && is_op_search)
        begin
            orow_reg  <= '0;
            ocol_reg  <= '0;
            dir_reg   <= '0;
            count_reg <= '0;
            len_reg   <= req.word_length;
        end
        if (cmd.line_init)
        begin
            cur_r_reg <= {1'b0, orow_reg};
            cur_c_reg <= {1'b0, ocol_reg};
            step_reg  <= '0;
        end
        else if (cmd.advance)
        begin
            cur_r_reg <= cur_r_reg + {{(POS_RW-2){dr[1]}}, dr};
            cur_c_reg <= cur_c_reg + {{(POS_CW-2){dc[1]}}, dc};
            step_reg  <= step_reg + LEN_W'(1);
        end
        if (cmd.count_inc && count_reg != COUNT_MAX)
            count_reg <= count_reg + COUNT_W'(1);
        if (cmd.next_line)
        begin
            dir_reg <= dir_reg + DIR_W'(1);
            if (dir_reg == LAST_DIR)
            begin
                if (ocol_reg == COL_W'(GRID_COLS - 1))
                begin
                    ocol_reg <= '0;
                    orow_reg <= orow_reg + ROW_W'(1);
                end
                else
                    ocol_reg <= ocol_reg + COL_W'(1);
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cell_sel_reg  <= is_op_read && in_grid;
            res_count_reg <= '0;
            res_bad_reg   <= is_op_search && status.req_bad;
        end
        else if (cmd.finish)
        begin
            res_count_reg <= count_reg;
            res_bad_reg   <= 1'b0;
        end
    end

    assign rsp.cell_value  = !cell_sel_reg   ? 8'h00 :
                             mark_rd_vld_reg ? mark_rd_reg : BLANK_MARK;
    assign rsp.match_count = res_count_reg;
    assign rsp.bad_request = res_bad_reg;

endmodule

`default_nettype wire

### design/grid_word_search_8dir.sv
// ----------------------------------------------------------------------------
// grid_word_search_8dir
// Eight-direction word search over an 8x8 letter grid with a mark grid.
// ----------------------------------------------------------------------------
// Every request word gives exactly one response word. Grid loads, word
// letter loads and mark reads are taken one per cycle while the response
// side does not stall; a mark read returns its cell the cycle after it is
// taken, through the registered mark grid port. A search holds the request
// side while the sequencer walks all 64 origins and 8 directions in order,
// one letter grid read per compare on the single letter grid read port:
// each line sets up its walk, then reads and compares one letter at a time
// until a mismatch, the grid edge or the last letter, and each match adds
// word_length mark writes. A search with a bad length answers without a
// walk. The mark grid is cleared by per-cell valid bits, so no
// clearing pass runs after reset or before a search.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_word_search_8dir
    import gws_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    gws_cmd_t    cmd;
    gws_status_t status;

    // Sequencer
    gws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_op    (req.op),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // Storage and walk datapath
    gws_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .rsp    (rsp)
    );

endmodule

`default_nettype wire

### dv/grid_word_search_8dir_tb.sv
// ----------------------------------------------------------------------------
// grid_word_search_8dir_tb
// Self-checking bench for the eight-direction word search block. A scoreboard
// class keeps its own letter grid, pattern store and mark grid and predicts
// the response word for every accepted request word. Stimulus opens with
// directed checks, then runs planted-pattern searches mixed with random
// noise through four phases of sender and receiver idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import gws_pkg::*;

class word_search_scoreboard;
    logic [7:0] letters [GRID_ROWS][GRID_COLS];
    logic [7:0] pattern [MAX_WORD];
    logic [7:0] marks [GRID_ROWS][GRID_COLS];
    rsp_t       pending [$];
    int         errors;
    int         row_step [8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
    int         col_step [8] = '{0, 1, 1, 1, 0, -1, -1, -1};

    function new();
        foreach (letters[r, c]) letters[r][c] = 8'h00;
        foreach (marks[r, c]) marks[r][c] = BLANK_MARK;
        foreach (pattern[i]) pattern[i] = 8'h00;
        errors = 0;
    endfunction

    // True when the first len pattern letters run from (r0, c0) along d
    function bit line_holds(int r0, int c0, int d, int len);
        int r;
        int c;
        int s;
        for (s = 0; s < len; s++) begin
            r = r0 + s * row_step[d];
            c = c0 + s * col_step[d];
            if (r < 0 || c < 0 || r >= GRID_ROWS || c >= GRID_COLS)
                return 1'b0;
            if (letters[r][c] != pattern[s])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Update the model for one accepted request word and queue its response
    function void note_request(req_t w);
        rsp_t e;
        int   len;
        int   s;
        e = '0;
        len = w.word_length;
        case (w.op)
            OP_LOAD_GRID: begin
                if (w.grid_row < GRID_ROWS && w.grid_col < GRID_COLS)
                    letters[w.grid_row][w.grid_col] = w.letter;
            end
            OP_LOAD_WORD: begin
                if (w.word_index < MAX_WORD)
                    pattern[w.word_index] = w.letter;
            end
            OP_SEARCH: begin
                if (len == 0 || len > MAX_WORD) begin
                    e.bad_request = 1'b1;
                end
                else begin
                    foreach (marks[r, c]) marks[r][c] = BLANK_MARK;
                    for (int r = 0; r < GRID_ROWS; r++)
                        for (int c = 0; c < GRID_COLS; c++)
                            for (int d = 0; d < 8; d++)
                                if (line_holds(r, c, d, len)) begin
                                    for (s = 0; s < len; s++)
                                        marks[r + s * row_step[d]][c + s * col_step[d]] =
                                            pattern[s];
                                    if (e.match_count != COUNT_MAX)
                                        e.match_count = e.match_count + 1'b1;
                                end
                end
            end
            OP_READ_MARK: begin
                if (w.grid_row < GRID_ROWS && w.grid_col < GRID_COLS)
                    e.cell_value = marks[w.grid_row][w.grid_col];
            end
        endcase
        pending.push_back(e);
    endfunction

    // Compare one accepted response word with the oldest expectation
    function void check_response(rsp_t got);
        rsp_t e;
        if (pending.size() == 0) begin
            $error("response word with nothing pending: cell_value %0d match_count %0d",
                   got.cell_value, got.match_count);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.cell_value !== e.cell_value) begin
            $error("cell_value: expected %0d, actual %0d", e.cell_value, got.cell_value);
            errors++;
        end
        if (got.match_count !== e.match_count) begin
            $error("match_count: expected %0d, actual %0d", e.match_count, got.match_count);
            errors++;
        end
        if (got.bad_request !== e.bad_request) begin
            $error("bad_request: expected %0d, actual %0d", e.bad_request, got.bad_request);
            errors++;
        end
    endfunction
endclass

module grid_word_search_8dir_tb;

    localparam int     CLK_HALF     = 4;
    localparam int     RESET_CYCLES = 11;
    localparam int     RANDOM_ITEMS = 1050;
    localparam int     TAIL_CYCLES  = 16;
    localparam longint CYCLE_LIMIT  = 10_000_000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    word_search_scoreboard sb;
    int         send_idle_pct;
    int         rsp_stall_pct;
    int         sent_items;
    longint     cycles = 0;
    logic [7:0] theme_base;
    int         theme_size;

    grid_word_search_8dir uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Stall the response side at random
    always @(negedge clk)
    begin
        rsp_stall <= rst_n && ($urandom_range(99) < rsp_stall_pct);
    end

    // Note accepted requests first, then check accepted responses
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (req_valid && !req_stall)
                sb.note_request(req);
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp);
        end
    end

    // Drop the run if it hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("grid_word_search_8dir_tb failed");
            $finish;
        end
    end

    // Request word with every field random; callers set the ones that matter
    function automatic req_t filler_word(op_t op);
        req_t w;
        w.op          = op;
        w.grid_row    = 3'($urandom_range(7));
        w.grid_col    = 3'($urandom_range(7));
        w.letter      = 8'($urandom_range(255));
        w.word_index  = 4'($urandom_range(15));
        w.word_length = 5'($urandom_range(31));
        return w;
    endfunction

    function automatic logic [7:0] theme_letter();
        return theme_base + 8'($urandom_range(theme_size - 1));
    endfunction

    // Present one request word from a falling edge; return at the falling
    // edge after it is taken, with valid still high
    task automatic send_word(input req_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req       = w;
        req_valid = 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
        sent_items++;
    endtask

    task automatic load_cell(input int r, input int c, input logic [7:0] l);
        req_t w;
        w = filler_word(OP_LOAD_GRID);
        w.grid_row = 3'(r);
        w.grid_col = 3'(c);
        w.letter   = l;
        send_word(w);
    endtask

    task automatic load_letter(input int i, input logic [7:0] l);
        req_t w;
        w = filler_word(OP_LOAD_WORD);
        w.word_index = 4'(i);
        w.letter     = l;
        send_word(w);
    endtask

    task automatic search(input int len);
        req_t w;
        w = filler_word(OP_SEARCH);
        w.word_length = 5'(len);
        send_word(w);
    endtask

    task automatic read_mark(input int r, input int c);
        req_t w;
        w = filler_word(OP_READ_MARK);
        w.grid_row = 3'(r);
        w.grid_col = 3'(c);
        send_word(w);
    endtask

    // Hold off the sender until every expected response has come back
    task automatic drain();
        req_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
    endtask

    // Directed checks; the grid and the whole pattern store get written
    // before the first search with a legal length
    task automatic directed_checks();
        read_mark(0, 0);
        read_mark(7, 7);
        // bad lengths touch no store
        search(0);
        search(17);
        search(31);
        for (int r = 0; r < GRID_ROWS; r++)
            for (int c = 0; c < GRID_COLS; c++)
                load_cell(r, c, 8'h00);
        for (int i = 0; i < MAX_WORD; i++)
            load_letter(i, 8'h00);
        // single letter word: eight hits at every origin
        search(1);
        read_mark(0, 0);
        // only full rows, columns and long diagonals fit
        search(8);
        read_mark(4, 3);
        // one step past every edge: nothing fits and the marks clear
        search(9);
        read_mark(4, 3);
        search(MAX_WORD);
        load_cell(7, 7, 8'hFF);
        load_letter(0, 8'hFF);
        search(1);
        read_mark(7, 7);
        read_mark(0, 7);
        // a rejected search leaves the marks alone
        search(20);
        read_mark(7, 7);
        load_letter(15, 8'hFF);
        search(MAX_WORD);
    endtask

    // Plant a pattern along a random line, search for it, read back the line
    task automatic plant_and_search();
        logic [7:0] pat [MAX_WORD];
        int  len;
        int  pick;
        int  r0;
        int  c0;
        int  d;
        int  re;
        int  ce;
        bit  placed;
        pick = $urandom_range(99);
        if (pick < 50)
            len = $urandom_range(1, 3);
        else if (pick < 85)
            len = $urandom_range(4, 8);
        else
            len = $urandom_range(9, MAX_WORD);
        // now and then refill the whole grid from a fresh alphabet
        if ($urandom_range(99) < 12) begin
            theme_base = 8'($urandom_range(255));
            theme_size = $urandom_range(1, 4);
            for (int r = 0; r < GRID_ROWS; r++)
                for (int c = 0; c < GRID_COLS; c++)
                    load_cell(r, c, theme_letter());
        end
        for (int i = 0; i < len; i++) begin
            pat[i] = theme_letter();
            load_letter(i, pat[i]);
        end
        repeat ($urandom_range(2, 8))
            load_cell($urandom_range(7), $urandom_range(7), theme_letter());
        placed = 1'b0;
        for (int t = 0; t < 8 && !placed; t++) begin
            r0 = $urandom_range(7);
            c0 = $urandom_range(7);
            d  = $urandom_range(7);
            re = r0 + (len - 1) * sb.row_step[d];
            ce = c0 + (len - 1) * sb.col_step[d];
            placed = re >= 0 && re < GRID_ROWS && ce >= 0 && ce < GRID_COLS;
        end
        if (placed)
            for (int s = 0; s < len; s++)
                load_cell(r0 + s * sb.row_step[d], c0 + s * sb.col_step[d], pat[s]);
        search(len);
        if (placed)
            for (int s = 0; s < len; s++)
                read_mark(r0 + s * sb.row_step[d], c0 + s * sb.col_step[d]);
        repeat ($urandom_range(1, 4))
            read_mark($urandom_range(7), $urandom_range(7));
    endtask

    // One request word of any kind with random content
    task automatic noise_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 35)
            send_word(filler_word(OP_LOAD_GRID));
        else if (pick < 55)
            send_word(filler_word(OP_LOAD_WORD));
        else if (pick < 92)
            send_word(filler_word(OP_READ_MARK));
        else
            send_word(filler_word(OP_SEARCH));
    endtask

    // Main sequence
    initial
    begin
        int random_start;
        clk           = 1'b0;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        rsp_stall     = 1'b0;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        sent_items    = 0;
        theme_base    = 8'h00;
        theme_size    = 2;
        sb = new();
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_checks();
        drain();

        random_start = sent_items;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin send_idle_pct = 46; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 46; end
                default: begin send_idle_pct = 19; rsp_stall_pct = 19; end
            endcase
            while (sent_items - random_start < (phase + 1) * RANDOM_ITEMS / 4) begin
                if ($urandom_range(99) < 60)
                    plant_and_search();
                else
                    noise_word();
            end
            drain();
        end

        // reads answer through the registered mark grid port; allow some margin
        repeat (TAIL_CYCLES)
            @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("grid_word_search_8dir_tb passed");
        else
            $display("grid_word_search_8dir_tb failed");
        $finish;
    end

endmodule
